@@ design/assert_macros.svh @@
// assertion macros used by the queue unit
// no dependencies; expects a clock named clk and a reset named rst in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define DEPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// expression must never be true outside reset
`define DEPQ_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

@@ design/depq_pkg.sv @@
// shared types and constants for the double-ended priority queue
// no dependencies
package depq_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int VALUE_W       = 32;
  localparam int ACTION_W      = 3;
  localparam int COUNT_FIELD_W = 5;

  localparam logic [ACTION_W-1:0] ACT_INSERT   = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_FIND_MIN = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_FIND_MAX = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_DEL_MIN  = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_DEL_MAX  = 3'd4;

  localparam logic [VALUE_W-1:0] EMPTY_RESULT = '1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_SHIFT,
    ST_PLACE,
    ST_DONE
  } state_t;

endpackage

@@ design/depq_store.sv @@
// value store of the queue: one write port, one read port, registered read data
// depends on depq_pkg
module depq_store #(
  parameter int DEPTH = depq_pkg::DEPTH_DEFAULT,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [AW-1:0]                        waddr,
  input  logic signed [depq_pkg::VALUE_W-1:0]  wdata,
  input  logic [AW-1:0]                        raddr,
  output logic signed [depq_pkg::VALUE_W-1:0]  rdata
);
  import depq_pkg::*;

  logic signed [VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ design/double_ended_priority_queue_unit.sv @@
// Double-ended priority queue of up to DEPTH signed 32-bit values, kept in
// ascending order in a circular region of one single-port-write memory.
// On an insert, larger entries move up one memory slot per cycle through the
// single read and write port. New requests stall until the current response
// is loaded. No clearing pass after reset.
// Depends on depq_pkg, depq_store and assert_macros.svh.
module double_ended_priority_queue_unit #(
  parameter int DEPTH = depq_pkg::DEPTH_DEFAULT
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       req_valid,
  output logic                                       req_stall,
  input  logic [depq_pkg::ACTION_W-1:0]              action,
  input  logic signed [depq_pkg::VALUE_W-1:0]        value,
  output logic                                       rsp_valid,
  input  logic                                       rsp_stall,
  output logic signed [depq_pkg::VALUE_W-1:0]        result_value,
  output logic                                       was_empty,
  output logic                                       was_full,
  output logic [depq_pkg::COUNT_FIELD_W-1:0]         entry_count
);
  import depq_pkg::*;
  `include "assert_macros.svh"

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  state_t state, state_next;

  logic [CW-1:0]              count, count_next;
  logic [AW-1:0]              head, head_next;
  logic [CW-1:0]              k, k_next;
  logic signed [VALUE_W-1:0]  val_q, val_next;
  logic signed [VALUE_W-1:0]  res_q, res_next;
  logic                       empty_q, empty_next;
  logic                       full_q, full_next;
  logic                       rsp_valid_next;

  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic signed [VALUE_W-1:0]  mem_wdata;
  logic [AW-1:0]              mem_raddr;
  logic signed [VALUE_W-1:0]  mem_rdata;

  logic accept;
  logic out_load;
  logic is_empty;
  logic is_full;

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                         input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + (CW+1)'(off);
    if (sum >= (CW+1)'(DEPTH)) begin
      sum = sum - (CW+1)'(DEPTH);
    end
    return AW'(sum);
  endfunction

  depq_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid && !req_stall;
  assign out_load  = (state == ST_DONE) && (!rsp_valid || !rsp_stall);
  assign is_empty  = (count == '0);
  assign is_full   = (count == CW'(DEPTH));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_DONE;
          unique case (action)
            ACT_INSERT: begin
              if (!is_full && !is_empty) begin
                state_next = ST_SHIFT;
              end
            end
            ACT_FIND_MIN, ACT_FIND_MAX: begin
              if (!is_empty) begin
                state_next = ST_LOOKUP;
              end
            end
            default: state_next = ST_DONE;
          endcase
        end
      end
      ST_LOOKUP: state_next = ST_DONE;
      ST_SHIFT: begin
        if (val_q < mem_rdata) begin
          if (k == '0) begin
            state_next = ST_PLACE;
          end
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_PLACE: state_next = ST_DONE;
      ST_DONE: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    count_next = count;
    head_next  = head;
    k_next     = k;
    val_next   = val_q;
    res_next   = res_q;
    empty_next = empty_q;
    full_next  = full_q;
    mem_we     = 1'b0;
    mem_waddr  = phys(head, CW'(k + CW'(1)));
    mem_wdata  = mem_rdata;
    mem_raddr  = phys(head, '0);
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          val_next   = value;
          empty_next = is_empty;
          full_next  = 1'b0;
          res_next   = '0;
          unique case (action)
            ACT_INSERT: begin
              if (is_full) begin
                full_next = 1'b1;
              end else if (is_empty) begin
                mem_we     = 1'b1;
                mem_waddr  = phys(head, '0);
                mem_wdata  = value;
                count_next = count + CW'(1);
              end else begin
                mem_raddr = phys(head, count - CW'(1));
                k_next    = count - CW'(1);
              end
            end
            ACT_FIND_MIN: begin
              if (is_empty) begin
                res_next = EMPTY_RESULT;
              end
            end
            ACT_FIND_MAX: begin
              if (is_empty) begin
                res_next = EMPTY_RESULT;
              end else begin
                mem_raddr = phys(head, count - CW'(1));
              end
            end
            ACT_DEL_MIN: begin
              if (!is_empty) begin
                head_next  = phys(head, CW'(1));
                count_next = count - CW'(1);
              end
            end
            ACT_DEL_MAX: begin
              if (!is_empty) begin
                count_next = count - CW'(1);
              end
            end
            default: res_next = '0;
          endcase
        end
      end
      ST_LOOKUP: res_next = mem_rdata;
      ST_SHIFT: begin
        mem_we = 1'b1;
        if (val_q < mem_rdata) begin
          // move the larger entry up one slot
          if (k != '0) begin
            mem_raddr = phys(head, k - CW'(1));
            k_next    = k - CW'(1);
          end
        end else begin
          mem_wdata  = val_q;
          count_next = count + CW'(1);
        end
      end
      ST_PLACE: begin
        mem_we     = 1'b1;
        mem_waddr  = phys(head, '0);
        mem_wdata  = val_q;
        count_next = count + CW'(1);
      end
      ST_DONE: res_next = res_q;
      default: res_next = res_q;
    endcase
  end

  always_comb begin
    if (out_load) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_valid && !rsp_stall) begin
      rsp_valid_next = 1'b0;
    end else begin
      rsp_valid_next = rsp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      head      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      head      <= head_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    k       <= k_next;
    val_q   <= val_next;
    res_q   <= res_next;
    empty_q <= empty_next;
    full_q  <= full_next;
    if (out_load) begin
      result_value <= res_q;
      was_empty    <= empty_q;
      was_full     <= full_q;
      entry_count  <= COUNT_FIELD_W'(count);
    end
  end

  `DEPQ_NEVER(a_count_bound, count > CW'(DEPTH), "entry count above depth")
  `DEPQ_ASSERT(a_accept_leaves_idle, accept |=> state != ST_IDLE, "idle after accept")
  `DEPQ_ASSERT(a_shift_in_range, state == ST_SHIFT |-> k < count, "shift position out of range")
  `DEPQ_ASSERT(a_write_states, mem_we |-> state != ST_LOOKUP && state != ST_DONE, "stray write")

endmodule
